// ----- rtl/core/scpd_pkg.sv -----
// Package for the sync/checksum packet deframer: reset values, register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package scpd_pkg;

  localparam int PACKET_BYTES_DEF = 31;

  localparam logic [7:0] SYNC_RESET = 8'hCF;
  localparam logic [4:0] OFF1_RESET = 5'd5;
  localparam logic [4:0] OFF2_RESET = 5'd17;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_OFFSET = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic write_byte;  // store accepted item at window tail
    logic scan_rd;     // read window head
    logic drop_one;    // discard window head
    logic sum_clear;   // clear checksum and word accumulators
    logic sum_rd;      // read next packet byte for checksum
    logic load_out;    // load result register; consume packet, or drop its head on bad sum
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic is_sync;     // last head read equals sync value
    logic sum_last;    // current sum read is the last byte
    logic out_free;    // result register can take a new item
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/scpd_dp.sv -----
// Datapath of the packet deframer: circular window memory, head/fill
// pointers, checksum and word accumulators, config and result registers.
// Depends on scpd_pkg.
`default_nettype none

module scpd_dp #(
  parameter int PACKET_BYTES = scpd_pkg::PACKET_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wen,
  input  wire logic [scpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [7:0]                       rx_byte,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic                                  frame_status,
  output logic [31:0]                           first_word,
  output logic [31:0]                           second_word,
  input  wire scpd_pkg::cmd_t                   cmd,
  output scpd_pkg::sts_t                        sts
);
  import scpd_pkg::*;

  localparam int IDX_W = $clog2(PACKET_BYTES);
  localparam int CNT_W = $clog2(PACKET_BYTES + 1);
  localparam int AW    = CNT_W + 1;
  localparam int DW    = ((IDX_W > 5) ? IDX_W : 5) + 1;

  logic [7:0]       sync_value;
  logic [4:0]       first_off;
  logic [4:0]       second_off;

  logic [7:0]       win_mem [PACKET_BYTES];
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] idx;

  logic [7:0]       rd_data;
  logic             rd_sum_vld;
  logic [IDX_W-1:0] rd_idx;

  logic [15:0]      sum_acc;
  logic [7:0]       got_hi;
  logic [7:0]       got_lo;
  logic [31:0]      word1;
  logic [31:0]      word2;

  logic [AW-1:0]    wsum;
  logic [AW-1:0]    rsum;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] head_inc;
  logic             csum_ok;
  logic [DW-1:0]    diff1;
  logic [DW-1:0]    diff2;
  logic             hit1;
  logic             hit2;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
      first_off  <= OFF1_RESET;
      second_off <= OFF2_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_SYNC_VALUE:    sync_value <= cfg_wdata;
        CFG_FIRST_OFFSET:  first_off  <= cfg_wdata[4:0];
        CFG_SECOND_OFFSET: second_off <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // circular addressing, sums stay below twice the depth
  assign wsum  = AW'(head) + AW'(fill);
  assign waddr = (wsum >= AW'(PACKET_BYTES)) ? IDX_W'(wsum - AW'(PACKET_BYTES))
                                             : IDX_W'(wsum);
  assign rsum  = AW'(head) + AW'(idx);
  assign raddr = cmd.scan_rd ? head :
                 ((rsum >= AW'(PACKET_BYTES)) ? IDX_W'(rsum - AW'(PACKET_BYTES))
                                              : IDX_W'(rsum));
  assign head_inc = (head == IDX_W'(PACKET_BYTES - 1)) ? '0 : head + IDX_W'(1);

  assign csum_ok = (sum_acc == {got_hi, got_lo});

  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      win_mem[waddr] <= rx_byte;
    end
    if (cmd.scan_rd || cmd.sum_rd) begin
      rd_data <= win_mem[raddr];
    end
    rd_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_sum_vld <= 1'b0;
    end else begin
      rd_sum_vld <= cmd.sum_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.write_byte) begin
      fill <= fill + CNT_W'(1);
    end else if (cmd.drop_one || (cmd.load_out && !csum_ok)) begin
      head <= head_inc;
      fill <= fill - CNT_W'(1);
    end else if (cmd.load_out) begin
      fill <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.sum_clear) begin
      idx <= '0;
    end else if (cmd.sum_rd) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // byte position relative to each word offset; bytes past the end stay zero
  assign diff1 = DW'(rd_idx) - DW'(first_off);
  assign diff2 = DW'(rd_idx) - DW'(second_off);
  assign hit1  = !diff1[DW-1] && (diff1[DW-2:2] == '0);
  assign hit2  = !diff2[DW-1] && (diff2[DW-2:2] == '0);

  always_ff @(posedge clk) begin
    if (cmd.sum_clear) begin
      sum_acc <= '0;
      word1   <= '0;
      word2   <= '0;
    end else if (rd_sum_vld) begin
      if (rd_idx < IDX_W'(PACKET_BYTES - 2)) begin
        sum_acc <= sum_acc + 16'(rd_data);
      end else if (rd_idx == IDX_W'(PACKET_BYTES - 2)) begin
        got_hi <= rd_data;
      end else begin
        got_lo <= rd_data;
      end
      if (hit1) begin
        word1[8*(3 - int'(diff1[1:0])) +: 8] <= rd_data;
      end
      if (hit2) begin
        word2[8*(3 - int'(diff2[1:0])) +: 8] <= rd_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frame_status <= !csum_ok;
      first_word   <= csum_ok ? word1 : 32'd0;
      second_word  <= csum_ok ? word2 : 32'd0;
    end
  end

  always_comb begin
    sts.fill_zero = (fill == '0);
    sts.fill_full = (fill == CNT_W'(PACKET_BYTES));
    sts.is_sync   = (rd_data == sync_value);
    sts.sum_last  = (idx == IDX_W'(PACKET_BYTES - 1));
    sts.out_free  = !out_valid || out_ready;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(PACKET_BYTES))
    else $error("window fill beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= IDX_W'(PACKET_BYTES - 1))
    else $error("window head out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.write_byte |-> !sts.fill_full)
    else $error("byte written into full window");

  a_good_consumes: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && csum_ok) |=> fill == '0)
    else $error("good packet not consumed");

endmodule

`default_nettype wire

// ----- rtl/core/scpd_ctrl.sv -----
// Controller of the packet deframer: sequences append, sync hunt,
// checksum pass and result load. Depends on scpd_pkg.
`default_nettype none

module scpd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output scpd_pkg::cmd_t       cmd,
  input  wire scpd_pkg::sts_t  sts
);
  import scpd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_RD  = 6'b000010,
    S_SCAN_CHK = 6'b000100,
    S_SUM      = 6'b001000,
    S_SUM_WAIT = 6'b010000,
    S_CHECK    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.write_byte = !sts.fill_full;
          state_next     = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.fill_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!sts.is_sync) begin
          cmd.drop_one = 1'b1;
          state_next   = S_SCAN_RD;
        end else if (sts.fill_full) begin
          cmd.sum_clear = 1'b1;
          state_next    = S_SUM;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SUM: begin
        cmd.sum_rd = 1'b1;
        if (sts.sum_last) begin
          state_next = S_SUM_WAIT;
        end
      end
      S_SUM_WAIT: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending item");

  a_sum_after_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_clear |=> state == S_SUM)
    else $error("checksum pass did not start");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.write_byte |=> state == S_SCAN_RD)
    else $error("append not followed by sync hunt");

endmodule

`default_nettype wire

// ----- rtl/core/sync_checksum_packet_deframer.sv -----
// Top level of the sync-byte packet deframer with 16-bit sum checksum.
// Joins scpd_ctrl and scpd_dp; depends on scpd_pkg.
`default_nettype none

// Channel   Handshake            Payload
// cfg       cfg_wen              cfg_index[1:0], cfg_wdata[7:0]
// in        in_valid / in_ready  rx_byte[7:0]
// out       out_valid / out_ready frame_status, first_word[31:0], second_word[31:0]
//
// Sequence: append, then a memory read and a compare per head byte examined
//   in the sync hunt, and one more check when the window runs empty. A full
//   window only forms with no byte dropped, so a packet check is one compare
//   plus PACKET_BYTES reads, a drain state and the load. The longest item
//   hunts through a full window of non-sync bytes.
// Reset: rst is synchronous; empties the window and restores register
//   defaults. Window memory is not cleared; only filled entries are read.
// Stalls: the result sits in an output register; a new item is taken while
//   it waits, and only a second result waits for the first to be taken.
module sync_checksum_packet_deframer #(
  parameter int PACKET_BYTES = scpd_pkg::PACKET_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wen,
  input  wire logic [scpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  frame_status,
  output logic [31:0]                           first_word,
  output logic [31:0]                           second_word
);
  import scpd_pkg::*;

  // command and status buses between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: append, hunt for sync, checksum pass, load result
  scpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // window memory, checksum/word accumulators, config and result registers
  scpd_dp #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .rx_byte      (rx_byte),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .frame_status (frame_status),
    .first_word   (first_word),
    .second_word  (second_word),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

`default_nettype wire

// ----- tb/sync_checksum_packet_deframer_tb.sv -----
// Self-checking testbench for sync_checksum_packet_deframer: sends bytes,
// predicts packet results with its own deframer model and compares each one.
// Depends on scpd_pkg and the RTL under rtl/core.
`default_nettype none

module sync_checksum_packet_deframer_tb;
  import scpd_pkg::*;

  localparam int PKT_LEN = PACKET_BYTES_DEF;
  // worst case from the top-level notes: sync hunt through a full window
  localparam int BLOCK_LATENCY = 2 * PKT_LEN + 2;
  localparam int GAP_PCT = 27;
  localparam int MAX_SHOWN = 10;

  typedef enum logic {
    FRAME_OK      = 1'b0,
    FRAME_BAD_SUM = 1'b1
  } frame_status_e;

  typedef struct packed {
    frame_status_e status;
    logic [31:0]   first;
    logic [31:0]   second;
  } frame_t;

  typedef logic [7:0] bytes_t[$];

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic                  frame_status;
  logic [31:0]           first_word;
  logic [31:0]           second_word;

  // Predictor state: the byte window and its copy of the registers.
  logic [7:0] win [0:PKT_LEN-1];
  int         win_fill;
  logic [7:0] sync_reg;
  logic [4:0] first_off_reg;
  logic [4:0] second_off_reg;

  frame_t expected_frames[$];

  // Run bookkeeping.
  int  bytes_sent;
  int  frames_predicted;
  int  bad_frames_predicted;
  int  frames_checked;
  int  mismatch_count;
  int  leftover_count;
  int  settings_count;
  bit  send_gaps;
  bit  recv_gaps;
  int  hold_cycles;

  sync_checksum_packet_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_status (frame_status),
    .first_word   (first_word),
    .second_word  (second_word)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Deframer predictor
  // ---------------------------------------------------------------------------

  // Remove count bytes from the window head.
  function automatic void win_drop(input int count);
    if (count >= win_fill) begin
      win_fill = 0;
      return;
    end
    for (int k = 0; k < win_fill - count; k++) begin
      win[k] = win[k + count];
    end
    win_fill -= count;
  endfunction

  // Big-endian word at a packet offset; bytes past the packet end read as zero.
  function automatic logic [31:0] win_word(input logic [4:0] off);
    logic [31:0] w;
    int pos;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      pos = int'(off) + k;
      w = {w[23:0], (pos < PKT_LEN) ? win[pos] : 8'h00};
    end
    return w;
  endfunction

  // One accepted byte: append, hunt for sync, check a full window.
  function automatic void deframe_byte(input logic [7:0] b);
    int          lead;
    logic [15:0] sum;
    logic [15:0] carried;
    frame_t      f;
    if (win_fill < PKT_LEN) begin
      win[win_fill] = b;
      win_fill++;
    end
    lead = 0;
    while (lead < win_fill && win[lead] != sync_reg) lead++;
    win_drop(lead);
    if (win_fill < PKT_LEN) return;

    sum = '0;
    for (int k = 0; k < PKT_LEN - 2; k++) begin
      sum += 16'(win[k]);
    end
    carried = {win[PKT_LEN-2], win[PKT_LEN-1]};
    if (sum == carried) begin
      f.status = FRAME_OK;
      f.first  = win_word(first_off_reg);
      f.second = win_word(second_off_reg);
      win_drop(PKT_LEN);
    end else begin
      // rejected: words zero, only the sync byte goes
      f.status = FRAME_BAD_SUM;
      f.first  = '0;
      f.second = '0;
      win_drop(1);
      bad_frames_predicted++;
    end
    expected_frames.push_back(f);
    frames_predicted++;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Packet under the current sync value; payload constant or random, and
  // optionally one bit flipped after the sum so the checksum fails.
  function automatic bytes_t make_packet(input bit use_fill, input logic [7:0] fill,
                                         input bit corrupt);
    bytes_t      p;
    logic [15:0] s;
    int          pos;
    p.push_back(sync_reg);
    for (int k = 1; k < PKT_LEN - 2; k++) begin
      p.push_back(use_fill ? fill : 8'($urandom_range(0, 255)));
    end
    s = '0;
    foreach (p[k]) s += 16'(p[k]);
    p.push_back(s[15:8]);
    p.push_back(s[7:0]);
    if (corrupt) begin
      pos = $urandom_range(1, PKT_LEN - 1);
      p[pos] = p[pos] ^ (8'd1 << $urandom_range(0, 7));
    end
    return p;
  endfunction

  function automatic bytes_t make_noise(input int count);
    bytes_t p;
    for (int k = 0; k < count; k++) p.push_back(8'($urandom_range(0, 255)));
    return p;
  endfunction

  // Offer one item; valid holds with the payload until the block takes it.
  task automatic send_item(input logic [7:0] b);
    @(negedge clk);
    while (send_gaps && $urandom_range(0, 99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_bytes(input bytes_t bs);
    foreach (bs[k]) send_item(bs[k]);
  endtask

  // Sender stops and waits until every predicted frame has come out.
  task automatic drain_frames();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // Register writes only on an idle block: a byte that made no frame may
  // still be in the sync hunt, so give it the full latency as well.
  task automatic set_registers(input logic [7:0] sync_v, input logic [4:0] off1,
                               input logic [4:0] off2);
    logic [2:0] junk;
    drain_frames();
    repeat (2 * BLOCK_LATENCY) @(posedge clk);
    // upper data bits of the offset writes are don't-care
    junk = 3'($urandom_range(0, 7));
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_SYNC_VALUE;
    cfg_wdata <= sync_v;
    @(negedge clk);
    cfg_index <= CFG_FIRST_OFFSET;
    cfg_wdata <= {junk, off1};
    @(negedge clk);
    cfg_index <= CFG_SECOND_OFFSET;
    cfg_wdata <= {~junk, off2};
    @(negedge clk);
    cfg_wen <= 1'b0;
    sync_reg       = sync_v;
    first_off_reg  = off1;
    second_off_reg = off2;
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values in use: default sync and offsets, no register written yet.
  task automatic test_default_registers();
    send_bytes('{8'h00, 8'hFF, 8'h5A});
    send_bytes(make_packet(1'b0, 8'h00, 1'b0));
    send_bytes(make_packet(1'b0, 8'h00, 1'b1));
    send_bytes(make_packet(1'b1, 8'hFF, 1'b0));
  endtask

  // Register extremes, offsets whose word runs past the packet end, and a
  // truncated packet that makes the next real one fail first.
  task automatic test_register_extremes();
    set_registers(8'h00, 5'd1, 5'd25);
    send_bytes(make_packet(1'b1, 8'h00, 1'b0));
    send_bytes(make_packet(1'b1, 8'hFF, 1'b0));
    set_registers(8'hFF, 5'd0, 5'd28);
    send_bytes(make_packet(1'b0, 8'h00, 1'b0));
    set_registers(8'hA5, 5'd31, 5'd27);
    send_bytes(make_packet(1'b0, 8'h00, 1'b0));
    send_bytes('{8'hA5, 8'h11, 8'h22, 8'h33});
    send_bytes(make_packet(1'b0, 8'h00, 1'b0));
  endtask

  // Mostly well-formed packets with random content, plus corrupted packets,
  // noise and cut-off packets; register settings change every phase.
  task automatic test_random_traffic();
    int    start_bytes;
    int    phase_bytes;
    int    phase;
    int    pick;
    logic [4:0] off1;
    logic [4:0] off2;
    bytes_t unit;
    start_bytes  = bytes_sent;
    phase_bytes  = 0;
    phase        = 0;
    while (bytes_sent - start_bytes < 380) begin
      if (phase_bytes >= 140) begin
        phase++;
        phase_bytes = 0;
        off1 = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(1, 25));
        off2 = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(1, 25));
        set_registers(8'($urandom_range(0, 255)), off1, off2);
        // one long phase with no idling on either side
        send_gaps = (phase != 2);
        recv_gaps = (phase != 2);
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        unit = make_packet(1'b0, 8'h00, 1'b0);
      end else if (pick < 80) begin
        unit = make_packet(1'b0, 8'h00, 1'b1);
      end else if (pick < 90) begin
        unit = make_noise($urandom_range(1, 8));
      end else begin
        // packet cut short: sync and a few bytes
        unit = make_noise($urandom_range(1, 12));
        unit.push_front(sync_reg);
      end
      send_bytes(unit);
      phase_bytes += unit.size();
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // Receiver holds off while packets keep coming, so the block backs up and
  // stalls its input; then the sender waits for everything to drain.
  task automatic test_output_holdoff();
    @(posedge clk);
    hold_cycles = 600;
    repeat (4) send_bytes(make_packet(1'b0, 8'h00, 1'b0));
    send_bytes(make_packet(1'b0, 8'h00, 1'b1));
    drain_frames();
    repeat (2) send_bytes(make_packet(1'b0, 8'h00, 1'b0));
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    frame_t exp_f;
    if (!rst && out_valid && out_ready) begin
      frames_checked++;
      if (expected_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("unexpected frame: status %0d first %08h second %08h",
                   frame_status, first_word, second_word);
        end
      end else begin
        exp_f = expected_frames.pop_front();
        if (frame_status !== exp_f.status || first_word !== exp_f.first ||
            second_word !== exp_f.second) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("frame %0d mismatch: status exp %0d got %0d,",
                     frames_checked, exp_f.status, frame_status);
            $display("  first exp %08h got %08h, second exp %08h got %08h",
                     exp_f.first, first_word, exp_f.second, second_word);
          end
        end
      end
    end
  end

  // Receiver: random idling, or a counted hold-off when a test asks for it.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (!recv_gaps) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int waited;
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_index = CFG_SYNC_VALUE;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    out_ready = 1'b0;

    win_fill       = 0;
    sync_reg       = SYNC_RESET;
    first_off_reg  = OFF1_RESET;
    second_off_reg = OFF2_RESET;
    foreach (win[k]) win[k] = '0;
    bytes_sent           = 0;
    frames_predicted     = 0;
    bad_frames_predicted = 0;
    frames_checked       = 0;
    mismatch_count       = 0;
    leftover_count       = 0;
    settings_count       = 1;
    send_gaps            = 1'b1;
    recv_gaps            = 1'b1;
    hold_cycles          = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_registers();
    test_register_extremes();
    test_random_traffic();
    test_output_holdoff();

    // wait out the tail, bounded
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_frames.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * BLOCK_LATENCY) @(posedge clk);
    leftover_count = expected_frames.size();
    if (leftover_count != 0) begin
      $display("%0d expected frames never came out", leftover_count);
    end

    $display("Run: %0d bytes, %0d frames checked (%0d rejected on checksum),",
             bytes_sent, frames_checked, bad_frames_predicted);
    $display("     %0d register settings, %0d mismatches", settings_count, mismatch_count);
    if (mismatch_count == 0 && leftover_count == 0) begin
      $display("** sync_checksum_packet_deframer: PASSED **");
    end else begin
      $display("** sync_checksum_packet_deframer: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("timeout waiting on the block");
    $display("** sync_checksum_packet_deframer: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
